@@ rtl/sat_pkg.sv @@
// Package for the section address translator.
// Holds the payload structs, table entry layout, opcodes, register indexes
// and the controller state type. Depends on nothing.
package sat_pkg;

    // Opcodes carried in the input item
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_FILE2VIR = 2'd1;
    localparam logic [1:0] OP_VIR2FILE = 2'd2;

    // Configuration register indexes
    localparam logic REG_SECTION_COUNT = 1'b0;
    localparam logic REG_IMAGE_BASE    = 1'b1;

    localparam int COUNT_W = 5;
    localparam int CFG_W   = 64;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  entry_index;
        logic [31:0] entry_file_start;
        logic [31:0] entry_file_size;
        logic [31:0] entry_virtual_start;
        logic [31:0] query_address;
        logic        add_base;
    } sat_in_t;

    typedef struct packed {
        logic        found;
        logic [63:0] result_address;
    } sat_out_t;

    // One section table entry as stored in memory
    typedef struct packed {
        logic [31:0] file_start;
        logic [31:0] file_size;
        logic [31:0] virtual_start;
    } sat_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM,
        ST_BASE
    } sat_state_t;

endpackage

@@ rtl/sat_section_mem.sv @@
// Section table memory: one write port, one registered read port.
// Entry layout comes from sat_pkg.
module sat_section_mem #(
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  sat_pkg::sat_entry_t wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output sat_pkg::sat_entry_t rd_data
);

    sat_pkg::sat_entry_t mem [DEPTH];
    sat_pkg::sat_entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/section_address_translator.sv @@
// Section address translator: a load writes the table on transfer. A query is accepted,
// checks table entries in index order up to the first hit (at most min(section_count,
// MAX_SECTIONS) of them) and forms the result in the sum and base states. The input is
// stalled until the result register takes the result, so any output stall holds it too.
// One item is in work at a time, bound by the single read port of the section memory.
// Reset clears control and config registers; table contents stay undefined until loaded.
module section_address_translator #(
    parameter int MAX_SECTIONS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  sat_pkg::sat_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output sat_pkg::sat_out_t           out_data,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [sat_pkg::CFG_W-1:0]   cfg_data
);

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

    // Configuration registers
    logic [sat_pkg::COUNT_W-1:0] section_count_reg;
    logic [63:0]                 image_base_reg;

    // Control and work registers
    sat_pkg::sat_state_t state_reg, state_next;
    logic              f2v_reg, f2v_next;
    logic              add_base_reg, add_base_next;
    logic [31:0]       query_reg, query_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              hit_reg, hit_next;
    logic [31:0]       off_reg, off_next;
    logic [31:0]       other_reg, other_next;
    logic [32:0]       sum_reg, sum_next;
    logic              out_valid_reg, out_valid_next;
    sat_pkg::sat_out_t out_data_reg, out_data_next;

    // Memory interface
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    sat_pkg::sat_entry_t wr_entry;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    sat_pkg::sat_entry_t rd_entry;

    // Scan datapath
    logic [31:0]      lo;
    logic [31:0]      other;
    logic [32:0]      hi;
    logic             entry_hit;
    logic             last_entry;
    logic [CNT_W-1:0] limit_calc;
    logic             in_xfer;
    logic             out_free;

    sat_section_mem #(
        .DEPTH (MAX_SECTIONS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_count_reg <= '0;
            image_base_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sat_pkg::REG_SECTION_COUNT:
                    section_count_reg <= cfg_data[sat_pkg::COUNT_W-1:0];
                sat_pkg::REG_IMAGE_BASE:
                    image_base_reg <= cfg_data;
                default:
                    image_base_reg <= image_base_reg;
            endcase
        end
    end

    assign in_stall  = (state_reg != sat_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the search count to the table depth
    assign limit_calc = (32'(section_count_reg) > MAX_SECTIONS)
                        ? CNT_W'(MAX_SECTIONS) : CNT_W'(section_count_reg);

    // Load writes straight into the table
    assign wr_en    = in_xfer && (in_data.opcode == sat_pkg::OP_LOAD)
                      && (32'(in_data.entry_index) < MAX_SECTIONS);
    assign wr_addr  = IDX_W'(in_data.entry_index);
    assign wr_entry = '{file_start:    in_data.entry_file_start,
                        file_size:     in_data.entry_file_size,
                        virtual_start: in_data.entry_virtual_start};

    // Range check of the entry read last cycle
    assign lo         = f2v_reg ? rd_entry.file_start : rd_entry.virtual_start;
    assign other      = f2v_reg ? rd_entry.virtual_start : rd_entry.file_start;
    assign hi         = {1'b0, lo} + {1'b0, rd_entry.file_size};
    assign entry_hit  = (lo <= query_reg) && ({1'b0, query_reg} < hi);
    assign last_entry = ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == limit_reg);

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        f2v_next       = f2v_reg;
        add_base_next  = add_base_reg;
        query_next     = query_reg;
        limit_next     = limit_reg;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        off_next       = off_reg;
        other_next     = other_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = chk_idx_reg + IDX_W'(1);

        case (state_reg)
            sat_pkg::ST_IDLE:
            begin
                if (in_xfer && (in_data.opcode == sat_pkg::OP_FILE2VIR
                                || in_data.opcode == sat_pkg::OP_VIR2FILE))
                begin
                    f2v_next      = (in_data.opcode == sat_pkg::OP_FILE2VIR);
                    add_base_next = in_data.add_base;
                    query_next    = in_data.query_address;
                    limit_next    = limit_calc;
                    chk_idx_next  = '0;
                    hit_next      = 1'b0;
                    if (limit_calc == '0)
                    begin
                        state_next = sat_pkg::ST_SUM;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = sat_pkg::ST_SCAN;
                    end
                end
            end
            sat_pkg::ST_SCAN:
            begin
                if (entry_hit)
                begin
                    hit_next   = 1'b1;
                    off_next   = query_reg - lo;
                    other_next = other;
                    state_next = sat_pkg::ST_SUM;
                end
                else if (last_entry)
                begin
                    state_next = sat_pkg::ST_SUM;
                end
                else
                begin
                    // Advance to the next entry
                    rd_en        = 1'b1;
                    chk_idx_next = chk_idx_reg + IDX_W'(1);
                end
            end
            sat_pkg::ST_SUM:
            begin
                sum_next   = {1'b0, off_reg} + {1'b0, other_reg};
                state_next = sat_pkg::ST_BASE;
            end
            sat_pkg::ST_BASE:
            begin
                // Hold until the result register is free
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_data_next.found = hit_reg;
                    if (!hit_reg)
                    begin
                        out_data_next.result_address = '0;
                    end
                    else if (f2v_reg && add_base_reg)
                    begin
                        out_data_next.result_address = 64'(sum_reg) + image_base_reg;
                    end
                    else
                    begin
                        out_data_next.result_address = 64'(sum_reg);
                    end
                    state_next = sat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sat_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sat_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        f2v_reg      <= f2v_next;
        add_base_reg <= add_base_next;
        query_reg    <= query_next;
        limit_reg    <= limit_next;
        chk_idx_reg  <= chk_idx_next;
        hit_reg      <= hit_next;
        off_reg      <= off_next;
        other_reg    <= other_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    // Scan never checks an entry past the clamped count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sat_pkg::ST_SCAN |-> CNT_W'(chk_idx_reg) < limit_reg)
        else $error("scan index beyond section count");

    // Sum stage always hands over to the base stage
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sat_pkg::ST_SUM |=> state_reg == sat_pkg::ST_BASE)
        else $error("sum stage did not advance");

    // A new result appears only from the base stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == sat_pkg::ST_BASE)
        else $error("result raised outside base stage");

    // A miss carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.found || out_data_reg.result_address == '0)
        else $error("miss with nonzero address");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for section_address_translator: a directed table, then
// random phases under several idle and stall mixes. Depends on sat_pkg and the RTL.
module testbench;

    localparam int         N_SLOTS       = 16;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         MAX_REPORTS   = 10;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        sat_pkg::sat_in_t  item;
        logic              cfg_index;
        logic [63:0]       cfg_value;
        bit                typed;
        sat_pkg::sat_out_t want;
    } dir_row_t;

    typedef struct {
        logic [4:0]  count;
        logic [63:0] base;
        int          send_idle;
        int          recv_stall;
        int          hold;
        int          items;
    } phase_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    sat_pkg::sat_in_t          in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    sat_pkg::sat_out_t         out_data;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_index = 1'b0;
    logic [sat_pkg::CFG_W-1:0] cfg_data  = '0;

    // Shadow copy of the section table and registers
    logic [31:0] shadow_fs [N_SLOTS];
    logic [31:0] shadow_sz [N_SLOTS];
    logic [31:0] shadow_vs [N_SLOTS];
    logic [4:0]  shadow_count = '0;
    logic [63:0] shadow_base  = '0;

    sat_pkg::sat_out_t pending_translations[$];
    dir_row_t          directed_rows[$];
    phase_t            phases[6];

    int error_count     = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int hits_checked    = 0;
    int register_writes = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_budget     = 0;
    int hold_taken      = 0;

    always #2 clk = ~clk;

    section_address_translator #(
        .MAX_SECTIONS(N_SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    // Update the shadow table on a load; compute the translation of a query
    function automatic bit translate(input sat_pkg::sat_in_t it,
                                     output sat_pkg::sat_out_t res);
        int          limit;
        logic [31:0] range_lo;
        logic [31:0] other;
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] q;
        logic [32:0] sum;
        res = '0;
        if (it.opcode == sat_pkg::OP_LOAD)
        begin
            shadow_fs[it.entry_index] = it.entry_file_start;
            shadow_sz[it.entry_index] = it.entry_file_size;
            shadow_vs[it.entry_index] = it.entry_virtual_start;
            return 1'b0;
        end
        if (it.opcode == OP_UNUSED)
            return 1'b0;
        limit = (shadow_count > 5'd16) ? N_SLOTS : int'(shadow_count);
        q = {1'b0, it.query_address};
        for (int k = 0; k < limit; k++)
        begin
            range_lo = (it.opcode == sat_pkg::OP_FILE2VIR) ? shadow_fs[k] : shadow_vs[k];
            other    = (it.opcode == sat_pkg::OP_FILE2VIR) ? shadow_vs[k] : shadow_fs[k];
            lo = {1'b0, range_lo};
            hi = lo + {1'b0, shadow_sz[k]};
            // first hit in index order wins
            if (!res.found && q >= lo && q < hi)
            begin
                sum = (q - lo) + {1'b0, other};
                res.found = 1'b1;
                res.result_address = {31'b0, sum};
                if (it.opcode == sat_pkg::OP_FILE2VIR && it.add_base)
                    res.result_address = res.result_address + shadow_base;
            end
        end
        return 1'b1;
    endfunction

    // Random item; queries mostly aim inside or at the edges of a live section
    function automatic sat_pkg::sat_in_t random_item(input logic [1:0] op);
        sat_pkg::sat_in_t it;
        int               limit;
        int               k;
        int               style;
        logic [31:0]      lo;
        logic [31:0]      size;
        logic [32:0]      spot;
        it.opcode              = op;
        it.entry_index         = 4'($urandom_range(N_SLOTS - 1));
        it.entry_file_start    = $urandom;
        it.entry_file_size     = $urandom;
        it.entry_virtual_start = $urandom;
        it.query_address       = $urandom;
        it.add_base            = 1'($urandom_range(1));
        if (op == sat_pkg::OP_LOAD)
        begin
            // keep most sections short so queries can land in them
            style = $urandom_range(19);
            if (style < 10)
                it.entry_file_size = 32'($urandom_range(32'h2000, 1));
            else if (style < 14)
                it.entry_file_size &= 32'h00FF_FFFF;
            else if (style < 16)
                it.entry_file_size = '0;
            else if (style == 16)
                it.entry_file_size = '1;
            // push some sections to the top of the space or onto another one
            style = $urandom_range(9);
            if (style < 2)
                it.entry_file_start = 32'hFFFF_FFFF - 32'($urandom_range(32'h3000));
            else if (style < 4)
                it.entry_file_start = shadow_fs[$urandom_range(N_SLOTS - 1)];
            style = $urandom_range(9);
            if (style < 2)
                it.entry_virtual_start = 32'hFFFF_FFFF - 32'($urandom_range(32'h3000));
            else if (style < 4)
                it.entry_virtual_start = shadow_vs[$urandom_range(N_SLOTS - 1)];
        end
        else if (op != OP_UNUSED)
        begin
            limit = (shadow_count > 5'd16) ? N_SLOTS : int'(shadow_count);
            if (limit > 0)
            begin
                k     = $urandom_range(limit - 1);
                lo    = (op == sat_pkg::OP_FILE2VIR) ? shadow_fs[k] : shadow_vs[k];
                size  = shadow_sz[k];
                style = $urandom_range(9);
                if (style < 6)
                    spot = {1'b0, lo} + ((size == 0) ? 33'd0 : 33'($urandom % size));
                else if (style == 6)
                    spot = {1'b0, lo} + {1'b0, size} - 33'd1;
                else if (style == 7)
                    spot = {1'b0, lo} + {1'b0, size};
                else if (style == 8)
                    spot = {1'b0, lo} - 33'd1;
                else
                    spot = {1'b0, it.query_address};
                // clamp past the top of the space onto its last byte
                it.query_address = spot[32] ? 32'hFFFF_FFFF : spot[31:0];
            end
        end
        return it;
    endfunction

    function automatic dir_row_t query_row(input logic [1:0] op, input logic [31:0] addr,
                                           input logic add, input bit typed = 1'b0,
                                           input logic found = 1'b0,
                                           input logic [63:0] want = '0);
        dir_row_t row;
        row.kind                    = ROW_ITEM;
        row.item                    = random_item(op);
        row.item.query_address      = addr;
        row.item.add_base           = add;
        row.cfg_index               = 1'b0;
        row.cfg_value               = '0;
        row.typed                   = typed;
        row.want.found              = found;
        row.want.result_address     = want;
        return row;
    endfunction

    function automatic dir_row_t load_row(input logic [3:0] slot, input logic [31:0] fs,
                                          input logic [31:0] sz, input logic [31:0] vs);
        dir_row_t row;
        row = query_row(sat_pkg::OP_LOAD, $urandom, 1'($urandom_range(1)));
        row.item.entry_index         = slot;
        row.item.entry_file_start    = fs;
        row.item.entry_file_size     = sz;
        row.item.entry_virtual_start = vs;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic idx, input logic [63:0] value);
        dir_row_t row;
        row = query_row(OP_UNUSED, '0, 1'b0);
        row.kind      = ROW_CFG;
        row.cfg_index = idx;
        row.cfg_value = value;
        return row;
    endfunction

    // Offer one item, hold it until the transfer, then predict its result
    task automatic transfer_item(input sat_pkg::sat_in_t it, input bit typed,
                                 input sat_pkg::sat_out_t want);
        sat_pkg::sat_out_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_accepted++;
        if (translate(it, predicted))
            pending_translations.push_back(typed ? want : predicted);
    endtask

    // Drop valid, wait for every result, then let a load or a scan finish
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_translations.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_idle(input logic idx, input logic [63:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == sat_pkg::REG_SECTION_COUNT)
            shadow_count = value[4:0];
        else
            shadow_base = value;
        register_writes++;
    endtask

    // Output side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin : result_side
        sat_pkg::sat_out_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_translations.size() == 0)
                note_failure($sformatf("unexpected result found=%0b addr=%h",
                                       out_data.found, out_data.result_address));
            else
            begin
                want = pending_translations.pop_front();
                results_checked++;
                if (out_data.found !== want.found ||
                    out_data.result_address !== want.result_address)
                    note_failure($sformatf({"result %0d: expected found=%0b addr=%h, ",
                                            "got found=%0b addr=%h"},
                                           results_checked, want.found, want.result_address,
                                           out_data.found, out_data.result_address));
                else if (want.found)
                    hits_checked++;
            end
        end
        if (hold_taken < hold_budget)
        begin
            out_stall <= 1'b1;
            hold_taken++;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #4_000_000;
        $display("Timeout: the run did not drain");
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int                pick;
        logic [1:0]        op;
        sat_pkg::sat_out_t none;
        dir_row_t          row;
        none = '0;
        foreach (shadow_fs[i])
        begin
            shadow_fs[i] = '0;
            shadow_sz[i] = '0;
            shadow_vs[i] = '0;
        end

        // Empty table, then three sections: a plain one, one whose end passes
        // 2^32, and an empty one
        directed_rows.push_back(cfg_row(sat_pkg::REG_SECTION_COUNT, 64'd0));
        directed_rows.push_back(cfg_row(sat_pkg::REG_IMAGE_BASE, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(query_row(sat_pkg::OP_FILE2VIR, 32'h0, 1'b1, 1'b1, 1'b0,
                                          64'h0));
        directed_rows.push_back(query_row(sat_pkg::OP_VIR2FILE, 32'hFFFF_FFFF, 1'b0, 1'b1,
                                          1'b0, 64'h0));
        directed_rows.push_back(query_row(OP_UNUSED, 32'h400, 1'b1));
        directed_rows.push_back(load_row(4'd0, 32'h0000_0400, 32'h0000_1000, 32'h0000_1000));
        directed_rows.push_back(load_row(4'd1, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed_rows.push_back(load_row(4'd2, 32'h0, 32'h0, 32'h0));
        directed_rows.push_back(cfg_row(sat_pkg::REG_SECTION_COUNT, 64'd3));
        directed_rows.push_back(query_row(sat_pkg::OP_FILE2VIR, 32'h0000_0400, 1'b0, 1'b1,
                                          1'b1, 64'h0000_1000));
        directed_rows.push_back(query_row(sat_pkg::OP_FILE2VIR, 32'h0000_13FF, 1'b1));
        directed_rows.push_back(query_row(sat_pkg::OP_FILE2VIR, 32'h0000_1400, 1'b0, 1'b1,
                                          1'b0, 64'h0));
        directed_rows.push_back(query_row(sat_pkg::OP_FILE2VIR, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                          1'b1, 64'h0000_0001_0000_0FFD));
        directed_rows.push_back(query_row(sat_pkg::OP_FILE2VIR, 32'hFFFF_F000, 1'b0, 1'b1,
                                          1'b1, 64'h0000_0000_FFFF_FFFF));
        // base is ignored on the reverse direction
        directed_rows.push_back(query_row(sat_pkg::OP_VIR2FILE, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                          1'b1, 64'h0000_0000_FFFF_F000));
        directed_rows.push_back(query_row(sat_pkg::OP_VIR2FILE, 32'h0000_1FFF, 1'b0));
        directed_rows.push_back(query_row(sat_pkg::OP_VIR2FILE, 32'h0, 1'b0, 1'b1, 1'b0,
                                          64'h0));
        directed_rows.push_back(query_row(sat_pkg::OP_FILE2VIR, 32'h0000_03FF, 1'b1, 1'b1,
                                          1'b0, 64'h0));
        directed_rows.push_back(cfg_row(sat_pkg::REG_IMAGE_BASE, 64'd0));
        directed_rows.push_back(cfg_row(sat_pkg::REG_SECTION_COUNT, 64'd1));
        directed_rows.push_back(query_row(sat_pkg::OP_FILE2VIR, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                          1'b0, 64'h0));
        directed_rows.push_back(query_row(sat_pkg::OP_VIR2FILE, 32'h0000_1000, 1'b1, 1'b1,
                                          1'b1, 64'h0000_0400));
        directed_rows.push_back(load_row(4'd15, $urandom, 32'h0000_0100, $urandom));

        phases[0] = '{5'd16, {$urandom, $urandom}, 0, 0, 0, 200};
        phases[1] = '{5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 53, 0, 0, 200};
        phases[2] = '{5'd0, 64'd0, 0, 53, 0, 100};
        phases[3] = '{5'($urandom_range(15, 1)), {$urandom, $urandom}, 22, 22, 0, 200};
        phases[4] = '{5'd16, {$urandom, $urandom}, 0, 0, 400, 200};
        phases[5] = '{5'd5, {$urandom, $urandom}, 0, 53, 0, 200};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_idle(directed_rows[r].cfg_index, directed_rows[r].cfg_value);
            else
                transfer_item(directed_rows[r].item, directed_rows[r].typed,
                              directed_rows[r].want);
        end

        // Load every slot before any count can reach an unloaded one
        for (int s = 0; s < N_SLOTS; s++)
        begin
            row = load_row(4'(s), $urandom, 32'($urandom_range(32'h4000, 1)), $urandom);
            transfer_item(row.item, 1'b0, none);
        end

        foreach (phases[p])
        begin
            write_idle(sat_pkg::REG_SECTION_COUNT, {59'd0, phases[p].count});
            write_idle(sat_pkg::REG_IMAGE_BASE, phases[p].base);
            send_idle_pct  = phases[p].send_idle;
            recv_stall_pct = phases[p].recv_stall;
            for (int n = 0; n < phases[p].items; n++)
            begin
                // hold the output off while the input keeps offering
                if (n == phases[p].items / 4 && phases[p].hold > 0)
                    hold_budget <= hold_budget + phases[p].hold;
                if ($urandom_range(99) < 4)
                    transfer_item(random_item(OP_UNUSED), 1'b0, none);
                pick = $urandom_range(99);
                op = (pick < 25) ? sat_pkg::OP_LOAD :
                     (pick < 62) ? sat_pkg::OP_FILE2VIR : sat_pkg::OP_VIR2FILE;
                transfer_item(random_item(op), 1'b0, none);
            end
        end

        settle();
        $display("Covered %0d transfers in, %0d results checked (%0d hits), %0d register writes,",
                 items_accepted, results_checked, hits_checked, register_writes);
        $display("with counts 0 to 31, idle and stall mixes and one long output hold.");
        if (error_count == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches in total", error_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
